>>> rtl/triangle_cotangent_weights_unit_assert.svh
// Assertion macros for the checker file.
`ifndef TRIANGLE_COTANGENT_WEIGHTS_UNIT_ASSERT_SVH
`define TRIANGLE_COTANGENT_WEIGHTS_UNIT_ASSERT_SVH

// Clocked check, masked while reset is applied.
`define TCW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds through reset.
`define TCW_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/tcw_pkg.sv
package tcw_pkg;

  localparam int INDEX_BITS = 16;
  localparam int COORD_BITS = 24;
  localparam int EDGE_W     = 25;
  localparam int WEIGHT_W   = 32;
  localparam int ENTRIES    = 6;

  localparam logic signed [WEIGHT_W-1:0] WEIGHT_MAX = {1'b0, {(WEIGHT_W-1){1'b1}}};
  localparam logic signed [WEIGHT_W-1:0] WEIGHT_MIN = {1'b1, {(WEIGHT_W-1){1'b0}}};

  typedef logic [INDEX_BITS-1:0]        idx_t;
  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [EDGE_W-1:0]     edge_t;
  typedef logic signed [WEIGHT_W-1:0]   weight_t;
  typedef edge_t [2:0]                  vec_t;

  typedef struct packed {
    idx_t   vert_a;
    idx_t   vert_b;
    idx_t   vert_c;
    coord_t a_x;
    coord_t a_y;
    coord_t a_z;
    coord_t b_x;
    coord_t b_y;
    coord_t b_z;
    coord_t c_x;
    coord_t c_y;
    coord_t c_z;
  } in_item_t;

  typedef struct packed {
    idx_t    row_index;
    idx_t    col_index;
    weight_t weight;
    logic    degenerate;
    logic    last_entry;
  } out_item_t;

  typedef struct packed {
    idx_t vi;
    idx_t vj;
    idx_t vk;
    vec_t ij;
    vec_t jk;
    vec_t ki;
  } edge_item_t;

  typedef struct packed {
    logic    idle;
    logic    done;
    weight_t weight;
    logic    degen;
  } corner_res_t;

  typedef struct packed {
    idx_t    vi;
    idx_t    vj;
    idx_t    vk;
    weight_t wi;
    weight_t wj;
    weight_t wk;
    logic    di;
    logic    dj;
    logic    dk;
  } tri_res_t;

endpackage

>>> rtl/tcw_front.sv
module tcw_front import tcw_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_item_t   in_item,
  output logic       q_valid,
  input  logic       q_pop,
  output edge_item_t q_item
);

  localparam int DIFF_W  = (COORD_BITS + 1 > EDGE_W) ? COORD_BITS + 1 : EDGE_W;
  localparam int EDGE_SH = (COORD_BITS > 24) ? COORD_BITS - 24 : 0;

  // floor-shifted difference, fits the edge width
  function automatic edge_t edge_of(coord_t to, coord_t from);
    logic signed [DIFF_W-1:0] d;
    logic signed [DIFF_W-1:0] s;
    d = DIFF_W'(to) - DIFF_W'(from);
    s = d >>> EDGE_SH;
    return s[EDGE_W-1:0];
  endfunction

  edge_item_t ent;
  edge_item_t q_mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;
  logic       push;

  always_comb begin
    ent.vi    = in_item.vert_a;
    ent.vj    = in_item.vert_b;
    ent.vk    = in_item.vert_c;
    ent.ij[0] = edge_of(in_item.b_x, in_item.a_x);
    ent.ij[1] = edge_of(in_item.b_y, in_item.a_y);
    ent.ij[2] = edge_of(in_item.b_z, in_item.a_z);
    ent.jk[0] = edge_of(in_item.c_x, in_item.b_x);
    ent.jk[1] = edge_of(in_item.c_y, in_item.b_y);
    ent.jk[2] = edge_of(in_item.c_z, in_item.b_z);
    ent.ki[0] = edge_of(in_item.a_x, in_item.c_x);
    ent.ki[1] = edge_of(in_item.a_y, in_item.c_y);
    ent.ki[2] = edge_of(in_item.a_z, in_item.c_z);
  end

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_item   = q_mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= ent;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (q_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      cnt_r <= cnt_r + 2'(push) - 2'(q_pop);
    end
  end

endmodule

>>> rtl/tcw_corner.sv
module tcw_corner import tcw_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        ack,
  input  vec_t        u,
  input  vec_t        w,
  output corner_res_t res
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_SQ   = 3'd2;
  localparam logic [2:0] ST_SQRT = 3'd3;
  localparam logic [2:0] ST_PREP = 3'd4;
  localparam logic [2:0] ST_DIV  = 3'd5;
  localparam logic [2:0] ST_DONE = 3'd6;

  localparam int PROD_W = 2 * EDGE_W;          // one edge product
  localparam int DOT_W  = PROD_W + 2;
  localparam int CRS_W  = PROD_W + 1;
  localparam int MAG_W  = PROD_W;
  localparam int HALF_W = MAG_W / 2 + 1;       // low half for squaring
  localparam int SUM_W  = 2 * MAG_W;
  localparam int ROOT_W = MAG_W;
  localparam int REM_W  = ROOT_W + 1;
  localparam int Q_W    = WEIGHT_W - 1;
  localparam int FRAC_W = 15;
  localparam int DLO_W  = Q_W - FRAC_W;
  localparam int OP_W   = HALF_W + 1;
  localparam int MUL_STEPS = 9;

  logic [2:0]               st_r;
  logic [5:0]               cnt_r;
  vec_t                     u_r, w_r;
  logic signed [DOT_W-1:0]  dot_r;
  logic signed [CRS_W-1:0]  cx_r, cy_r, cz_r;
  logic [SUM_W-1:0]         sum_r, sum_nxt, rad_r, sq_term;
  logic [ROOT_W-1:0]        root_r;
  logic [REM_W-1:0]         rem_r;
  logic [REM_W+1:0]         rem2, rem_sub;
  logic [ROOT_W+1:0]        trial;
  logic                     ge_s;
  logic [MAG_W-1:0]         dr_r;
  logic [MAG_W:0]           dr2;
  logic                     ge_d;
  logic [Q_W-1:0]           q_r, q_nxt, dbits_r;
  weight_t                  weight_r;
  logic                     degen_r;

  logic signed [OP_W-1:0]   ma, mb;
  logic signed [2*OP_W-1:0] prod;
  logic signed [PROD_W-1:0] pe;
  logic signed [CRS_W-1:0]  csel;
  logic [MAG_W-1:0]         cmag, dmag;
  logic [DOT_W-1:0]         dabs;
  logic [1:0]               part;
  logic                     dneg;

  // operand select for the shared multiplier
  always_comb begin
    ma   = '0;
    mb   = '0;
    csel = cx_r;
    part = 2'd0;
    if (st_r == ST_MUL) begin
      case (cnt_r)
        6'd0: begin ma = OP_W'(u_r[0]); mb = OP_W'(w_r[0]); end
        6'd1: begin ma = OP_W'(u_r[1]); mb = OP_W'(w_r[1]); end
        6'd2: begin ma = OP_W'(u_r[2]); mb = OP_W'(w_r[2]); end
        6'd3: begin ma = OP_W'(u_r[1]); mb = OP_W'(w_r[2]); end
        6'd4: begin ma = OP_W'(u_r[2]); mb = OP_W'(w_r[1]); end
        6'd5: begin ma = OP_W'(u_r[2]); mb = OP_W'(w_r[0]); end
        6'd6: begin ma = OP_W'(u_r[0]); mb = OP_W'(w_r[2]); end
        6'd7: begin ma = OP_W'(u_r[0]); mb = OP_W'(w_r[1]); end
        default: begin ma = OP_W'(u_r[1]); mb = OP_W'(w_r[0]); end
      endcase
    end else begin
      case (cnt_r) inside
        [6'd0:6'd2]: csel = cx_r;
        [6'd3:6'd5]: csel = cy_r;
        default:     csel = cz_r;
      endcase
      case (cnt_r) inside
        6'd0, 6'd3, 6'd6: part = 2'd0;
        6'd1, 6'd4, 6'd7: part = 2'd1;
        default:          part = 2'd2;
      endcase
      case (part)
        2'd0: begin
          ma = OP_W'({1'b0, cmag[HALF_W-1:0]});
          mb = OP_W'({1'b0, cmag[HALF_W-1:0]});
        end
        2'd1: begin
          ma = OP_W'({1'b0, cmag[MAG_W-1:HALF_W]});
          mb = OP_W'({1'b0, cmag[HALF_W-1:0]});
        end
        default: begin
          ma = OP_W'({1'b0, cmag[MAG_W-1:HALF_W]});
          mb = OP_W'({1'b0, cmag[MAG_W-1:HALF_W]});
        end
      endcase
    end
  end

  always_comb begin
    logic [CRS_W-1:0] ctmp;
    ctmp = csel[CRS_W-1] ? CRS_W'(-csel) : CRS_W'(csel);
    cmag = ctmp[MAG_W-1:0];
  end

  assign prod = ma * mb;
  assign pe   = prod[PROD_W-1:0];

  always_comb begin
    case (part)
      2'd0:    sq_term = SUM_W'(prod[2*HALF_W-1:0]);
      2'd1:    sq_term = SUM_W'(prod[2*HALF_W-1:0]) << (HALF_W + 1);
      default: sq_term = SUM_W'(prod[2*HALF_W-1:0]) << (2 * HALF_W);
    endcase
  end
  assign sum_nxt = sum_r + sq_term;

  // one root bit per step
  assign rem2    = {rem_r, rad_r[SUM_W-1:SUM_W-2]};
  assign trial   = {root_r, 2'b01};
  assign ge_s    = rem2 >= (REM_W+2)'(trial);
  assign rem_sub = rem2 - (REM_W+2)'(trial);

  // one quotient bit per step
  assign dr2   = {dr_r, dbits_r[Q_W-1]};
  assign ge_d  = dr2 >= {1'b0, root_r};
  assign q_nxt = {q_r[Q_W-2:0], ge_d};

  // cotangent numerator is minus dot(u, w)
  assign dneg = !dot_r[DOT_W-1] && (dot_r != '0);
  assign dabs = dot_r[DOT_W-1] ? DOT_W'(-dot_r) : DOT_W'(dot_r);
  assign dmag = dabs[MAG_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= ST_IDLE;
      cnt_r <= '0;
    end else begin
      unique case (st_r)
        ST_IDLE: begin
          if (start) begin
            u_r   <= u;
            w_r   <= w;
            dot_r <= '0;
            cx_r  <= '0;
            cy_r  <= '0;
            cz_r  <= '0;
            sum_r <= '0;
            cnt_r <= '0;
            st_r  <= ST_MUL;
          end
        end
        ST_MUL: begin
          case (cnt_r)
            6'd0, 6'd1, 6'd2: dot_r <= dot_r + DOT_W'(pe);
            6'd3: cx_r <= cx_r + CRS_W'(pe);
            6'd4: cx_r <= cx_r - CRS_W'(pe);
            6'd5: cy_r <= cy_r + CRS_W'(pe);
            6'd6: cy_r <= cy_r - CRS_W'(pe);
            6'd7: cz_r <= cz_r + CRS_W'(pe);
            default: cz_r <= cz_r - CRS_W'(pe);
          endcase
          if (cnt_r == 6'(MUL_STEPS - 1)) begin
            cnt_r <= '0;
            st_r  <= ST_SQ;
          end else begin
            cnt_r <= cnt_r + 6'd1;
          end
        end
        ST_SQ: begin
          sum_r <= sum_nxt;
          if (cnt_r == 6'(MUL_STEPS - 1)) begin
            rad_r  <= sum_nxt;
            root_r <= '0;
            rem_r  <= '0;
            cnt_r  <= '0;
            st_r   <= ST_SQRT;
          end else begin
            cnt_r <= cnt_r + 6'd1;
          end
        end
        ST_SQRT: begin
          rad_r  <= rad_r << 2;
          rem_r  <= ge_s ? rem_sub[REM_W-1:0] : rem2[REM_W-1:0];
          root_r <= {root_r[ROOT_W-2:0], ge_s};
          if (cnt_r == 6'(ROOT_W - 1)) begin
            cnt_r <= '0;
            st_r  <= ST_PREP;
          end else begin
            cnt_r <= cnt_r + 6'd1;
          end
        end
        ST_PREP: begin
          if (sum_r == '0) begin
            degen_r  <= 1'b1;
            weight_r <= dneg ? WEIGHT_MIN : WEIGHT_MAX;
            st_r     <= ST_DONE;
          end else if ((dmag >> DLO_W) >= MAG_W'(root_r)) begin
            degen_r  <= 1'b0;
            weight_r <= dneg ? WEIGHT_MIN : WEIGHT_MAX;
            st_r     <= ST_DONE;
          end else begin
            degen_r <= 1'b0;
            dr_r    <= dmag >> DLO_W;
            dbits_r <= {dmag[DLO_W-1:0], {FRAC_W{1'b0}}};
            q_r     <= '0;
            cnt_r   <= '0;
            st_r    <= ST_DIV;
          end
        end
        ST_DIV: begin
          dr_r    <= ge_d ? MAG_W'(dr2 - {1'b0, root_r}) : dr2[MAG_W-1:0];
          dbits_r <= dbits_r << 1;
          q_r     <= q_nxt;
          if (cnt_r == 6'(Q_W - 1)) begin
            weight_r <= dneg ? -weight_t'({1'b0, q_nxt}) : weight_t'({1'b0, q_nxt});
            st_r     <= ST_DONE;
          end else begin
            cnt_r <= cnt_r + 6'd1;
          end
        end
        ST_DONE: begin
          if (ack) begin
            st_r <= ST_IDLE;
          end
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end

  assign res.idle   = (st_r == ST_IDLE);
  assign res.done   = (st_r == ST_DONE);
  assign res.weight = weight_r;
  assign res.degen  = degen_r;

endmodule

>>> rtl/tcw_emit.sv
module tcw_emit import tcw_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      load,
  input  tri_res_t  tri_in,
  output logic      free,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  tri_res_t   tri_r;
  logic [2:0] cnt_r;
  logic       busy_r;
  logic       last;

  assign last      = (cnt_r == 3'(ENTRIES - 1));
  assign out_valid = busy_r;
  assign free      = !busy_r || (out_ready && last);

  always_comb begin
    out_item.last_entry = last;
    case (cnt_r)
      3'd0: begin
        out_item.row_index = tri_r.vi; out_item.col_index = tri_r.vj;
        out_item.weight = tri_r.wk; out_item.degenerate = tri_r.dk;
      end
      3'd1: begin
        out_item.row_index = tri_r.vj; out_item.col_index = tri_r.vi;
        out_item.weight = tri_r.wk; out_item.degenerate = tri_r.dk;
      end
      3'd2: begin
        out_item.row_index = tri_r.vj; out_item.col_index = tri_r.vk;
        out_item.weight = tri_r.wi; out_item.degenerate = tri_r.di;
      end
      3'd3: begin
        out_item.row_index = tri_r.vk; out_item.col_index = tri_r.vj;
        out_item.weight = tri_r.wi; out_item.degenerate = tri_r.di;
      end
      3'd4: begin
        out_item.row_index = tri_r.vk; out_item.col_index = tri_r.vi;
        out_item.weight = tri_r.wj; out_item.degenerate = tri_r.dj;
      end
      default: begin
        out_item.row_index = tri_r.vi; out_item.col_index = tri_r.vk;
        out_item.weight = tri_r.wj; out_item.degenerate = tri_r.dj;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (load) begin
      tri_r <= tri_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (load) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r && out_ready) begin
      if (last) begin
        busy_r <= 1'b0;
      end
      cnt_r <= cnt_r + 3'd1;
    end
  end

endmodule

>>> rtl/triangle_cotangent_weights_unit.sv
// Cotangent Laplacian weights for one triangle at a time.
// Input channel (in_valid/in_ready/in_item): one triangle per transfer,
//   three vertex indices and their Q8.16 positions.
// Output channel (out_valid/out_ready/out_item): six entries per triangle,
//   (i,j),(j,i) with half cot at K, (j,k),(k,j) at I, (k,i),(i,k) at J;
//   last_entry marks the sixth. Degenerate corners saturate the weight.
// Each corner unit runs its multiply, squaring, root, check and divide
//   steps in order; the divide is skipped for a degenerate or saturated
//   corner. The three corners run side by side, and the six entries of
//   one triangle drain while the next triangle is being computed. A new
//   triangle enters the corners only once the last has been handed on.
// The front stage computes the edges and parks up to two triangles in
//   its queue, so input keeps flowing while the corners are busy.
// Reset (rst_n low, synchronous) empties the queue, idles the corner
//   units and drops out_valid. Nothing is lost under output stall: a
//   finished triangle waits in the corner units until the output stage
//   takes it, and the queue then fills before in_ready drops.
module triangle_cotangent_weights_unit import tcw_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  logic        q_valid, q_pop;
  edge_item_t  q_item;
  corner_res_t res_i, res_j, res_k;
  logic        start, load, emit_free;
  logic        all_idle, all_done;
  idx_t        vi_r, vj_r, vk_r;
  tri_res_t    tri_res;

  // front: edge vectors and a two-deep queue
  tcw_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_item   (q_item)
  );

  assign all_idle = res_i.idle && res_j.idle && res_k.idle;
  assign all_done = res_i.done && res_j.done && res_k.done;
  assign start    = q_valid && all_idle;
  assign q_pop    = start;
  assign load     = all_done && emit_free;

  always_ff @(posedge clk) begin
    if (start) begin
      vi_r <= q_item.vi;
      vj_r <= q_item.vj;
      vk_r <= q_item.vk;
    end
  end

  // corner I: IJ against -KI, J: JK against -IJ, K: KI against -JK
  tcw_corner u_corner_i (
    .clk (clk), .rst_n (rst_n), .start (start), .ack (load),
    .u (q_item.ij), .w (q_item.ki), .res (res_i)
  );
  tcw_corner u_corner_j (
    .clk (clk), .rst_n (rst_n), .start (start), .ack (load),
    .u (q_item.jk), .w (q_item.ij), .res (res_j)
  );
  tcw_corner u_corner_k (
    .clk (clk), .rst_n (rst_n), .start (start), .ack (load),
    .u (q_item.ki), .w (q_item.jk), .res (res_k)
  );

  always_comb begin
    tri_res.vi = vi_r;
    tri_res.vj = vj_r;
    tri_res.vk = vk_r;
    tri_res.wi = res_i.weight;
    tri_res.wj = res_j.weight;
    tri_res.wk = res_k.weight;
    tri_res.di = res_i.degen;
    tri_res.dj = res_j.degen;
    tri_res.dk = res_k.degen;
  end

  // back: six entries out, one per transfer
  tcw_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (load),
    .tri_in    (tri_res),
    .free      (emit_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

>>> rtl/tcw_checker.sv
`include "triangle_cotangent_weights_unit_assert.svh"

module tcw_checker import tcw_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_item
);

  logic [2:0] pos_r;
  idx_t       prev_row_r, prev_col_r;
  weight_t    prev_w_r;
  logic       xfer;

  assign xfer = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else if (xfer) begin
      pos_r <= out_item.last_entry ? 3'd0 : pos_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (xfer) begin
      prev_row_r <= out_item.row_index;
      prev_col_r <= out_item.col_index;
      prev_w_r   <= out_item.weight;
    end
  end

  `TCW_ASSERT_RST(a_reset_quiet, !rst_n |=> !out_valid, "out_valid after reset")
  `TCW_ASSERT(a_stall_hold, out_valid && !out_ready |=> out_valid && $stable(out_item), "stalled entry changed")
  `TCW_ASSERT(a_last_pos, xfer |-> (out_item.last_entry == (pos_r == 3'(ENTRIES - 1))), "last_entry out of place")
  `TCW_ASSERT(a_pair_swap, xfer && pos_r[0] |-> out_item.row_index == prev_col_r && out_item.col_index == prev_row_r && out_item.weight == prev_w_r, "entry pair mismatch")

endmodule

bind triangle_cotangent_weights_unit tcw_checker u_tcw_checker (.*);

>>> test/triangle_cotangent_weights_unit_test.sv
`timescale 1ns / 1ps

module triangle_cotangent_weights_unit_test;
  import tcw_pkg::*;

  logic      clk;
  logic      rst_n;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;

  triangle_cotangent_weights_unit uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item)
  );

  localparam int  DRAIN_CYCLES = 400;
  localparam longint CYCLE_LIMIT = 10000000;

  in_item_t  triangles_pending[$];
  out_item_t entries_expected[$];
  int        mismatches = 0;
  longint    cycle_count = 0;
  bit        stimulus_done = 0;
  int        in_gap = 0;
  int        out_gap = 0;

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // Gap length: mostly short, occasionally long, sometimes none at all.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(20, 250);
  endfunction

  // Integer square root (floor) of a wide unsigned value.
  function automatic logic [103:0] isqrt(logic [103:0] s);
    logic [103:0] res;
    logic [103:0] c;
    res = '0;
    for (int b = 51; b >= 0; b--) begin
      c = res | (104'd1 << b);
      if (c * c <= s) res = c;
    end
    return res;
  endfunction

  // Half cotangent between edges u and v in Q16.16, truncated toward zero.
  function automatic void half_cotangent(input longint u[3], input longint v[3],
                                         output weight_t w, output logic dg);
    longint d, cx, cy, cz;
    logic [103:0] s, n, mag, q;
    d  = u[0]*v[0] + u[1]*v[1] + u[2]*v[2];
    cx = u[1]*v[2] - u[2]*v[1];
    cy = u[2]*v[0] - u[0]*v[2];
    cz = u[0]*v[1] - u[1]*v[0];
    s = 104'(cx < 0 ? -cx : cx) * 104'(cx < 0 ? -cx : cx)
      + 104'(cy < 0 ? -cy : cy) * 104'(cy < 0 ? -cy : cy)
      + 104'(cz < 0 ? -cz : cz) * 104'(cz < 0 ? -cz : cz);
    dg = (s == 0);
    if (dg) begin
      w = (d < 0) ? WEIGHT_MIN : WEIGHT_MAX;
      return;
    end
    n = isqrt(s);
    mag = 104'(d < 0 ? -d : d);
    q = (mag << 15) / n;
    if (q >= (104'd1 << 31))
      w = (d < 0) ? WEIGHT_MIN : WEIGHT_MAX;
    else if (d < 0)
      w = -weight_t'(q[31:0]);
    else
      w = weight_t'(q[31:0]);
  endfunction

  // Six entries a triangle adds to the Laplacian, in emission order.
  task automatic predict_entries(input in_item_t t);
    longint pa[3], pb[3], pc[3], ij[3], jk[3], ki[3];
    longint nij[3], njk[3], nki[3];
    weight_t wi, wj, wk;
    logic di, dj, dk;
    out_item_t e;
    pa = '{longint'(t.a_x), longint'(t.a_y), longint'(t.a_z)};
    pb = '{longint'(t.b_x), longint'(t.b_y), longint'(t.b_z)};
    pc = '{longint'(t.c_x), longint'(t.c_y), longint'(t.c_z)};
    for (int c = 0; c < 3; c++) begin
      ij[c] = pb[c] - pa[c];
      jk[c] = pc[c] - pb[c];
      ki[c] = pa[c] - pc[c];
      nij[c] = -ij[c];
      njk[c] = -jk[c];
      nki[c] = -ki[c];
    end
    half_cotangent(ij, nki, wi, di);
    half_cotangent(jk, nij, wj, dj);
    half_cotangent(ki, njk, wk, dk);
    e = '0;
    e = '{t.vert_a, t.vert_b, wk, dk, 1'b0}; entries_expected.push_back(e);
    e = '{t.vert_b, t.vert_a, wk, dk, 1'b0}; entries_expected.push_back(e);
    e = '{t.vert_b, t.vert_c, wi, di, 1'b0}; entries_expected.push_back(e);
    e = '{t.vert_c, t.vert_b, wi, di, 1'b0}; entries_expected.push_back(e);
    e = '{t.vert_c, t.vert_a, wj, dj, 1'b0}; entries_expected.push_back(e);
    e = '{t.vert_a, t.vert_c, wj, dj, 1'b1}; entries_expected.push_back(e);
  endtask

  function automatic in_item_t make_triangle(coord_t p[9]);
    in_item_t t;
    t.vert_a = idx_t'($urandom); t.vert_b = idx_t'($urandom);
    t.vert_c = idx_t'($urandom);
    {t.a_x, t.a_y, t.a_z, t.b_x, t.b_y, t.b_z, t.c_x, t.c_y, t.c_z} =
      {p[0], p[1], p[2], p[3], p[4], p[5], p[6], p[7], p[8]};
    return t;
  endfunction

  function automatic coord_t rand_coord(int mode);
    case (mode)
      0: return coord_t'($urandom);
      1: return coord_t'($signed($urandom_range(0, 131072)) - 65536);
      default: return coord_t'($signed($urandom_range(0, 2047)) - 1024);
    endcase
  endfunction

  // Stimulus: directed corner cases first, then random triangles.
  initial begin
    coord_t p[9];
    in_item_t t;
    int mode;
    // right triangle in the xy plane, unit legs
    p = '{0, 0, 0, 24'sh10000, 0, 0, 0, 24'sh10000, 0};
    triangles_pending.push_back(make_triangle(p));
    // all three vertices equal: every corner degenerate, dot zero
    p = '{24'sh1234, -24'sh55, 24'sh7, 24'sh1234, -24'sh55, 24'sh7,
          24'sh1234, -24'sh55, 24'sh7};
    triangles_pending.push_back(make_triangle(p));
    // collinear: degenerate with negative dot at the middle vertex
    p = '{0, 0, 0, 24'sh10000, 0, 0, 24'sh20000, 0, 0};
    triangles_pending.push_back(make_triangle(p));
    // coordinate extremes
    p = '{24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, -24'sh800000, -24'sh800000,
          -24'sh800000, 24'sh7FFFFF, -24'sh800000, 0};
    triangles_pending.push_back(make_triangle(p));
    p = '{-24'sh800000, 24'sh7FFFFF, 0, 24'sh7FFFFF, -24'sh800000, 24'sh7FFFFF,
          0, 0, -24'sh800000};
    triangles_pending.push_back(make_triangle(p));
    // very thin sliver: tiny cross, large dot, weight saturates
    p = '{0, 0, 0, 24'sh7FFFFF, 0, 0, -24'sh800000, 24'sh1, 0};
    triangles_pending.push_back(make_triangle(p));
    p = '{0, 0, 0, 24'sh7FFFFF, 24'sh1, 0, 24'sh3FFFFF, 0, 0};
    triangles_pending.push_back(make_triangle(p));
    // obtuse triangle, negative weight
    p = '{0, 0, 0, 24'sh40000, 0, 0, 24'sh20000, 24'sh800, 24'sh100};
    triangles_pending.push_back(make_triangle(p));
    // index extremes
    t = make_triangle(p);
    t.vert_a = '0; t.vert_b = '1; t.vert_c = 16'h8000;
    triangles_pending.push_back(t);
    t.vert_a = '1; t.vert_b = '1; t.vert_c = '1;
    triangles_pending.push_back(t);
    for (int n = 0; n < 500; n++) begin
      mode = $urandom_range(0, 2);
      for (int c = 0; c < 9; c++) p[c] = rand_coord(mode);
      // now and then make a vertex coincide or line up to hit degenerate paths
      if ($urandom_range(0, 19) == 0) p[6:8] = p[0:2];
      if ($urandom_range(0, 19) == 0)
        for (int c = 0; c < 3; c++) p[6+c] = coord_t'(p[c] + 2*(p[3+c] - p[c]));
      triangles_pending.push_back(make_triangle(p));
    end
    stimulus_done = 1;
  end

  // Driver: holds each triangle on the bus until its transfer.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap   <= pick_gap();
    end else if (in_valid && !in_ready) begin
      // hold
    end else begin
      if (in_valid) predict_entries(in_item);
      if (in_gap > 0 || (in_valid && $urandom_range(0, 9) == 0)) begin
        in_valid <= 1'b0;
        in_gap   <= (in_gap > 0) ? in_gap - 1 : pick_gap();
      end else if (triangles_pending.size() > 0) begin
        in_valid <= 1'b1;
        in_item  <= triangles_pending.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: checks each entry transfer against the oldest prediction.
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
      out_gap   <= pick_gap();
    end else begin
      if (out_valid && out_ready) begin
        if (entries_expected.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected entry %p", out_item);
        end else begin
          want = entries_expected.pop_front();
          if (out_item.row_index !== want.row_index ||
              out_item.col_index !== want.col_index ||
              out_item.weight !== want.weight ||
              out_item.degenerate !== want.degenerate ||
              out_item.last_entry !== want.last_entry) begin
            mismatches++;
            if (mismatches <= 10)
              $display("entry mismatch: expected %p got %p", want, out_item);
          end
        end
      end
      if (out_gap > 0) begin
        out_ready <= 1'b0;
        out_gap   <= out_gap - 1;
      end else if ($urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        out_gap   <= pick_gap();
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL triangle_cotangent_weights_unit");
      $finish;
    end
  end

  initial begin
    rst_n     = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    wait (stimulus_done && triangles_pending.size() == 0);
    @(posedge clk);
    while (in_valid || entries_expected.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && entries_expected.size() == 0)
      $display("PASS triangle_cotangent_weights_unit");
    else
      $display("FAIL triangle_cotangent_weights_unit");
    $finish;
  end

endmodule
